[design/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

   localparam int OP_W     = 1;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 11;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_NO_BLOCKS   = 2'd1,
      ST_DOUBLE_FREE = 2'd2,
      ST_RANGE       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       start;
      logic       advance;
      logic       write;
      logic       set_result;
      logic       grant;
      status_type res_status;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_free;
      logic range_err;
      logic op_free;
      logic past_lim;
      logic hit;
      logic bit_used;
      logic out_free;
   } sts_type;

endpackage

[design/bba_req_if.sv]
`timescale 1ns / 1ps

interface bba_req_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::OP_W-1:0]     opcode;
   logic [bba_pkg::INDEX_W-1:0]  block_index;

   modport source (output valid, output opcode, output block_index, input ready);
   modport sink (input valid, input opcode, input block_index, output ready);
endinterface

[design/bba_rsp_if.sv]
`timescale 1ns / 1ps

interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::INDEX_W-1:0]   granted_block;
   logic [bba_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output granted_block, output status, input ready);
   modport sink (input valid, input granted_block, input status, output ready);
endinterface

[design/bba_datapath.sv]
`timescale 1ns / 1ps

module bba_datapath #(
   parameter int NUM_BLOCKS    = 1024,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bba_pkg::TOTAL_W-1:0]   csr_wdata,
   input  logic [bba_pkg::OP_W-1:0]      req_opcode,
   input  logic [bba_pkg::INDEX_W-1:0]   req_index,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [bba_pkg::INDEX_W-1:0]   rsp_granted,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   input  bba_pkg::cmd_type              cmd,
   output bba_pkg::sts_type              sts
);

   localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int LIM_W0    = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_W     = (LIM_W0 > bba_pkg::TOTAL_W) ? LIM_W0 : bba_pkg::TOTAL_W;
   localparam int BASE_W    = $clog2((MAP_WORDS + 2) * MAP_WORD_BITS);
   localparam int CMP_W     = ((BASE_W > LIM_W) ? BASE_W : LIM_W) + 1;

   logic [MAP_WORD_BITS-1:0]      map_mem [MAP_WORDS];

   logic [bba_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic [BASE_W-1:0]             base_ff, base_in;
   logic [ADDR_W-1:0]             raddr_ff;
   logic [BASE_W-1:0]             rbase_ff;
   logic [MAP_WORD_BITS-1:0]      rdata_ff;
   logic [bba_pkg::OP_W-1:0]      op_ff, op_in;
   logic [bba_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic [bba_pkg::INDEX_W-1:0]   res_granted_ff, res_granted_in;
   logic [bba_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::INDEX_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic [bba_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [CMP_W-1:0]              total_x;
   logic [CMP_W-1:0]              lim;
   logic [CMP_W-1:0]              rbase_x;
   logic [CMP_W-1:0]              idx_x;
   logic [CMP_W-1:0]              remain;
   logic [CMP_W-1:0]              off;
   logic [CMP_W-1:0]              granted_calc;
   logic                          past_lim;
   logic                          in_word;
   logic [MAP_WORD_BITS-1:0]      avail;
   logic [BIT_W-1:0]              pos;
   logic [BIT_W-1:0]              off_bit;
   logic [MAP_WORD_BITS-1:0]      one_word;
   logic [MAP_WORD_BITS-1:0]      upd_word;
   logic [MAP_WORD_BITS-1:0]      wr_word;
   logic [ADDR_W-1:0]             wr_addr;
   logic                          mem_we;
   logic                          last_addr;

   // Effective block count is the register clamped to the map capacity.
   assign total_x = CMP_W'(total_ff);
   assign lim     = (total_x > CMP_W'(NUM_BLOCKS)) ? CMP_W'(NUM_BLOCKS) : total_x;
   assign rbase_x = CMP_W'(rbase_ff);
   assign idx_x   = CMP_W'(idx_ff);

   assign past_lim = (rbase_x >= lim);
   assign remain   = lim - rbase_x;

   always_comb begin
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         avail[i] = !rdata_ff[i] && (CMP_W'(i) < remain) && !past_lim;
      end
   end

   always_comb begin
      pos = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            pos = BIT_W'(i);
         end
      end
   end

   assign off      = idx_x - rbase_x;
   assign in_word  = (idx_x >= rbase_x) && (off < CMP_W'(MAP_WORD_BITS));
   assign off_bit  = off[BIT_W-1:0];
   assign one_word = {{(MAP_WORD_BITS - 1){1'b0}}, 1'b1};

   always_comb begin
      if (op_ff == bba_pkg::OP_FREE) begin
         upd_word = rdata_ff & ~(one_word << off_bit);
      end else begin
         upd_word = rdata_ff | (one_word << pos);
      end
   end

   assign granted_calc = rbase_x + CMP_W'(pos);

   assign last_addr = (addr_ff == ADDR_W'(MAP_WORDS - 1));
   assign mem_we    = cmd.clear || cmd.write;
   assign wr_addr   = cmd.clear ? addr_ff : raddr_ff;
   assign wr_word   = cmd.clear ? '0 : upd_word;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[wr_addr] <= wr_word;
      end
      rdata_ff <= map_mem[addr_ff];
   end

   always_comb begin
      total_in = csr_we ? csr_wdata : total_ff;

      addr_in = addr_ff;
      base_in = base_ff;
      op_in   = op_ff;
      idx_in  = idx_ff;
      if (cmd.start) begin
         addr_in = '0;
         base_in = '0;
         op_in   = req_opcode;
         idx_in  = req_index;
      end else if (cmd.advance || cmd.clear) begin
         if (!last_addr) begin
            addr_in = addr_ff + ADDR_W'(1);
         end
         if (cmd.advance) begin
            base_in = base_ff + BASE_W'(MAP_WORD_BITS);
         end
      end

      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      if (cmd.set_result) begin
         res_granted_in = cmd.grant ? granted_calc[bba_pkg::INDEX_W-1:0] : '0;
         res_status_in  = cmd.res_status;
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_granted_ff;
         rsp_status_in  = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= bba_pkg::TOTAL_RESET;
         addr_ff      <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         addr_ff      <= addr_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff       <= addr_ff;
      rbase_ff       <= base_ff;
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign sts.clr_last  = last_addr;
   assign sts.req_free  = (req_opcode == bba_pkg::OP_FREE);
   assign sts.range_err = (CMP_W'(req_index) >= lim);
   assign sts.op_free   = (op_ff == bba_pkg::OP_FREE);
   assign sts.past_lim  = past_lim;
   assign sts.hit       = (op_ff == bba_pkg::OP_FREE) ? in_word : (|avail);
   assign sts.bit_used  = rdata_ff[off_bit];
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

[design/bba_ctrl.sv]
`timescale 1ns / 1ps

module bba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bba_pkg::sts_type  sts,
   output bba_pkg::cmd_type  cmd
);

   bba_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            if (sts.clr_last) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               if (sts.req_free && sts.range_err) begin
                  state_in = bba_pkg::S_DONE;
               end else begin
                  state_in = bba_pkg::S_FETCH;
               end
            end
         end
         bba_pkg::S_FETCH: begin
            state_in = bba_pkg::S_WALK;
         end
         bba_pkg::S_WALK: begin
            if (sts.hit || (!sts.op_free && sts.past_lim)) begin
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_DONE: begin
            if (sts.out_free) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::S_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         bba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (sts.req_free && sts.range_err) begin
                  cmd.set_result = 1'b1;
                  cmd.res_status = bba_pkg::ST_RANGE;
               end
            end
         end
         bba_pkg::S_FETCH: begin
            cmd.advance = 1'b1;
         end
         bba_pkg::S_WALK: begin
            cmd.advance = 1'b1;
            if (sts.hit) begin
               cmd.set_result = 1'b1;
               if (sts.op_free) begin
                  if (sts.bit_used) begin
                     cmd.write      = 1'b1;
                     cmd.res_status = bba_pkg::ST_OK;
                  end else begin
                     cmd.res_status = bba_pkg::ST_DOUBLE_FREE;
                  end
               end else begin
                  cmd.write      = 1'b1;
                  cmd.grant      = 1'b1;
                  cmd.res_status = bba_pkg::ST_OK;
               end
            end else if (!sts.op_free && sts.past_lim) begin
               cmd.set_result = 1'b1;
               cmd.res_status = bba_pkg::ST_NO_BLOCKS;
            end
         end
         bba_pkg::S_DONE: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/bitmap_block_allocator_core.sv]
`timescale 1ns / 1ps
// Channel    Role       Handshake      Payload
// req_chan   sink       valid/ready    opcode, block_index
// rsp_chan   source     valid/ready    granted_block, status
// csr        write      csr_we         csr_wdata (total_blocks)
//
// The walk reads the bitmap words in order from word 0, one word per cycle from the map
// memory. Allocate: the walk stops at the word holding the first free block or, when
// none is free, once the base of the word it reads reaches the limit. Free: the walk
// stops at the target word; an out of range free skips the walk and goes straight to
// the response. After reset a clearing pass zeroes the map word by word (32 words by
// default) before the first request is taken. A stalled response lets the next
// transaction run up to its last state, where it waits until the output register is free.

module bitmap_block_allocator_core #(
   parameter int NUM_BLOCKS    = 1024,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   bba_req_if.sink                      req_chan,
   bba_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [bba_pkg::TOTAL_W-1:0]  csr_wdata
);

   bba_pkg::cmd_type cmd;
   bba_pkg::sts_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_datapath #(
      .NUM_BLOCKS    (NUM_BLOCKS),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_opcode  (req_chan.opcode),
      .req_index   (req_chan.block_index),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_granted (rsp_chan.granted_block),
      .rsp_status  (rsp_chan.status),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

[design/bba_checker.sv]
`timescale 1ns / 1ps

module bba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bba_pkg::INDEX_W-1:0]   rsp_granted_block,
   input logic [bba_pkg::STATUS_W-1:0]  rsp_status
);

   // A pending response is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Only a successful transaction can carry a nonzero block number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bba_pkg::ST_OK) |-> (rsp_granted_block == '0))
      else $error("nonzero block on a failed transaction");

   // The map is cleared before the first transaction is accepted.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request accepted during the clearing pass");

   // One transaction is processed at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_granted_block (rsp_chan.granted_block),
   .rsp_status        (rsp_chan.status)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int MAP_BLOCKS  = 1024;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      bba_pkg::op_type                op;
      logic [bba_pkg::INDEX_W-1:0]    index;
   } block_request_type;

   typedef struct packed {
      logic [bba_pkg::INDEX_W-1:0]    granted;
      bba_pkg::status_type            status;
   } block_result_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [bba_pkg::TOTAL_W-1:0]  csr_wdata;

   bba_req_if req_chan ();
   bba_rsp_if rsp_chan ();

   bitmap_block_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   block_request_type            pending_requests[$];
   block_result_type             expected_results[$];
   bit                           used_blocks[MAP_BLOCKS];
   logic [bba_pkg::TOTAL_W-1:0]  total_cfg;
   int                           send_idle_pct;
   int                           recv_stall_pct;
   int                           error_count;
   int                           cycle_count;
   int                           hold_requested;
   int                           hold_served;
   int                           hold_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic int block_limit();
      return (total_cfg > bba_pkg::TOTAL_W'(MAP_BLOCKS)) ? MAP_BLOCKS : int'(total_cfg);
   endfunction

   function automatic block_result_type predict_block_result(input block_request_type req);
      block_result_type res;
      int               lim;
      bit               found;
      lim = block_limit();
      res.granted = '0;
      found = 1'b0;
      if (req.op == bba_pkg::OP_ALLOC) begin
         res.status = bba_pkg::ST_NO_BLOCKS;
         for (int b = 0; b < lim; b++) begin
            if (!found && !used_blocks[b]) begin
               found = 1'b1;
               used_blocks[b] = 1'b1;
               res.granted = bba_pkg::INDEX_W'(b);
               res.status = bba_pkg::ST_OK;
            end
         end
      end else if (int'(req.index) >= lim) begin
         res.status = bba_pkg::ST_RANGE;
      end else if (!used_blocks[req.index]) begin
         res.status = bba_pkg::ST_DOUBLE_FREE;
      end else begin
         used_blocks[req.index] = 1'b0;
         res.status = bba_pkg::ST_OK;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      block_request_type next_req;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(predict_block_result(
               {bba_pkg::op_type'(req_chan.opcode), req_chan.block_index}));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.opcode <= next_req.op;
               req_chan.block_index <= next_req.index;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_requested != hold_served) begin
         hold_served <= hold_requested;
         hold_left <= 600;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      block_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction: block %0d status %0d",
                  rsp_chan.granted_block, rsp_chan.status));
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.granted_block !== want.granted)
                  report_mismatch($sformatf("granted_block %0d, expected %0d",
                     rsp_chan.granted_block, want.granted));
               if (rsp_chan.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                     rsp_chan.status, want.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_chan.valid || expected_results.size() != 0);
   endtask

   task automatic write_total(input logic [bba_pkg::TOTAL_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      total_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic queue_request(input bba_pkg::op_type op, input int index);
      pending_requests.push_back({op, bba_pkg::INDEX_W'(index)});
   endtask

   task automatic run_random(input int count, input int alloc_pct);
      int                freeable[$];
      int                sent;
      int                lim;
      int                roll;
      int                pick;
      block_request_type req;
      sent = 0;
      while (sent < count) begin
         do @(negedge clock);
         while (pending_requests.size() != 0 || req_chan.valid);
         lim = block_limit();
         freeable.delete();
         for (int b = 0; b < lim; b++)
            if (used_blocks[b]) freeable.push_back(b);
         for (int n = 0; n < 6 && sent < count; n++) begin
            roll = $urandom_range(99);
            req.index = bba_pkg::INDEX_W'($urandom);
            if (roll < alloc_pct) begin
               req.op = bba_pkg::OP_ALLOC;
            end else begin
               req.op = bba_pkg::OP_FREE;
               if (roll < 88 && freeable.size() != 0) begin
                  pick = $urandom_range(freeable.size() - 1);
                  req.index = bba_pkg::INDEX_W'(freeable[pick]);
                  freeable.delete(pick);
               end
            end
            pending_requests.push_back(req);
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.block_index = '0;
      rsp_chan.ready = 1'b0;
      total_cfg = bba_pkg::TOTAL_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      cycle_count = 0;
      hold_requested = 0;
      hold_served = 0;
      foreach (used_blocks[b]) used_blocks[b] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_request(bba_pkg::OP_ALLOC, 1023);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_ALLOC, 512);
      queue_request(bba_pkg::OP_FREE, 1);
      queue_request(bba_pkg::OP_FREE, 1);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_FREE, 0);
      queue_request(bba_pkg::OP_FREE, 1023);
      queue_request(bba_pkg::OP_FREE, 2);

      write_total(11'd0);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_FREE, 0);
      queue_request(bba_pkg::OP_FREE, 1023);

      write_total(11'd2047);
      queue_request(bba_pkg::OP_FREE, 1023);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_FREE, 0);

      write_total(11'd3);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_FREE, 3);
      queue_request(bba_pkg::OP_FREE, 1023);

      write_total(11'd1);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_ALLOC, 0);
      queue_request(bba_pkg::OP_FREE, 0);

      write_total(11'd1024);
      run_random(200, 70);

      write_total(11'd1);
      set_idling(72, 0);
      run_random(100, 50);

      write_total(11'd37);
      set_idling(0, 72);
      run_random(250, 55);

      write_total(11'd2047);
      set_idling(27, 27);
      run_random(200, 65);

      write_total(11'd0);
      set_idling(0, 0);
      run_random(40, 50);

      write_total(11'd64);
      set_idling(27, 27);
      hold_requested++;
      run_random(250, 60);

      write_total(11'd100);
      set_idling(72, 0);
      run_random(250, 50);

      write_total(11'd1024);
      set_idling(0, 72);
      run_random(260, 75);

      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
